FILE: rtl/nrcd_pkg.sv
// Shared types and constants for the nibble RLE column decoder.
`timescale 1ns / 1ps

package nrcd_pkg;

  localparam int DATA_W  = 8;
  localparam int COLOR_W = 8;
  localparam int FIELD_W = 6;
  localparam int PPC_W   = 6;
  localparam int CCNT_W  = 7;
  localparam int RUN_W   = 8;
  localparam int CMP_W   = 9;
  localparam int IDX_W   = 2;
  localparam int NIB_W   = 4;

  localparam logic [IDX_W-1:0] REG_PAIRS_PER_COLUMN = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLUMN_COUNT     = 2'd1;
  localparam logic [IDX_W-1:0] REG_BASE_COLOR       = 2'd2;

  localparam logic [PPC_W-1:0]   PPC_RESET   = 6'd12;
  localparam logic [CCNT_W-1:0]  CCNT_RESET  = 7'd24;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd224;
  localparam logic [PPC_W-1:0]   PPC_MIN     = 6'd4;

  localparam logic [DATA_W-1:0] REPEAT_FLAG = 8'd128;
  localparam logic [CMP_W-1:0]  REPEAT_BASE = 9'd257;

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_REPEAT  = 2'd2
  } mode_t;

  typedef struct packed {
    logic take_byte;
    logic emit_seg;
  } ctl_cmd_t;

  typedef struct packed {
    logic run_start;
    logic out_free;
    logic seg_final;
  } ctl_stat_t;

endpackage

FILE: rtl/nrcd_ctrl.sv
// Controller state machine: byte intake and segment sequencing.
`timescale 1ns / 1ps

module nrcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nrcd_pkg::ctl_stat_t stat,
  output nrcd_pkg::ctl_cmd_t  cmd
);
  import nrcd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.emit_seg  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (stat.run_start) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_seg = 1'b1;
          if (stat.seg_final) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/nrcd_datapath.sv
// Datapath: decode state, position counters, segment math and output register.
`timescale 1ns / 1ps

module nrcd_datapath #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_PAIRS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [nrcd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [nrcd_pkg::DATA_W-1:0]    cfg_data,
  input  logic [nrcd_pkg::DATA_W-1:0]    data_byte,
  input  logic                           out_ready,
  input  nrcd_pkg::ctl_cmd_t             cmd,
  output nrcd_pkg::ctl_stat_t            stat,
  output logic                           out_valid,
  output logic [nrcd_pkg::FIELD_W-1:0]   column,
  output logic [nrcd_pkg::FIELD_W-1:0]   start_row,
  output logic [nrcd_pkg::FIELD_W-1:0]   pair_count,
  output logic [nrcd_pkg::COLOR_W-1:0]   upper_color,
  output logic [nrcd_pkg::COLOR_W-1:0]   lower_color,
  output logic                           last,
  output logic                           image_done
);
  import nrcd_pkg::*;

  localparam int PIW = $clog2(MAX_PAIRS);
  localparam int PW  = $clog2(MAX_PAIRS + 1);
  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_COLUMNS + 1);

  logic [PPC_W-1:0]   pairs_per_column;
  logic [CCNT_W-1:0]  column_count;
  logic [COLOR_W-1:0] base_color;

  mode_t              mode;
  logic [RUN_W-1:0]   remaining_bytes;
  logic [RUN_W-1:0]   repeat_pending;
  logic [RUN_W-1:0]   run_left;
  logic [DATA_W-1:0]  pixel;
  logic [CIW-1:0]     cur_col;
  logic [PIW-1:0]     cur_pair;
  logic               finished;

  logic [PW-1:0]      eff_pairs;
  logic [CW-1:0]      eff_cols;
  logic [PW-1:0]      room;
  logic [PW-1:0]      seg_len;
  logic [PW:0]        pair_sum;
  logic               hit_bottom;
  logic               col_last;
  logic               seg_done;
  logic               run_end;
  logic [NIB_W-1:0]   up_nib;
  logic [NIB_W-1:0]   lo_nib;
  logic [COLOR_W-1:0] up_tint;
  logic [COLOR_W-1:0] lo_tint;

  always_comb begin
    if (pairs_per_column < PPC_MIN) begin
      eff_pairs = PW'(PPC_MIN);
    end else if (CMP_W'(pairs_per_column) > CMP_W'(MAX_PAIRS)) begin
      eff_pairs = PW'(MAX_PAIRS);
    end else begin
      eff_pairs = PW'(pairs_per_column);
    end

    if (column_count == '0) begin
      eff_cols = CW'(1);
    end else if (CMP_W'(column_count) > CMP_W'(MAX_COLUMNS)) begin
      eff_cols = CW'(MAX_COLUMNS);
    end else begin
      eff_cols = CW'(column_count);
    end

    if (PW'(cur_pair) < eff_pairs) begin
      room = eff_pairs - PW'(cur_pair);
    end else begin
      room = PW'(1);
    end

    if (CMP_W'(run_left) < CMP_W'(room)) begin
      seg_len = PW'(run_left);
    end else begin
      seg_len = room;
    end

    pair_sum   = {1'b0, PW'(cur_pair)} + {1'b0, seg_len};
    hit_bottom = pair_sum >= {1'b0, eff_pairs};
    col_last   = (CW'(cur_col) + CW'(1)) >= eff_cols;
    seg_done   = hit_bottom && col_last;
    run_end    = (CMP_W'(run_left) == CMP_W'(seg_len)) || seg_done;

    up_nib  = pixel[DATA_W-1:NIB_W];
    lo_nib  = pixel[NIB_W-1:0];
    up_tint = (up_nib != '0) ? (COLOR_W'(up_nib) | base_color) : '0;
    lo_tint = (lo_nib != '0) ? (COLOR_W'(lo_nib) | base_color) : '0;
  end

  assign stat.run_start = !finished && ((mode == MODE_LITERAL) || (mode == MODE_REPEAT));
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.seg_final = run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_per_column <= PPC_RESET;
      column_count     <= CCNT_RESET;
      base_color       <= COLOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAIRS_PER_COLUMN: pairs_per_column <= cfg_data[PPC_W-1:0];
        REG_COLUMN_COUNT:     column_count     <= cfg_data[CCNT_W-1:0];
        REG_BASE_COLOR:       base_color       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_CONTROL;
      remaining_bytes <= '0;
      repeat_pending  <= '0;
      cur_col         <= '0;
      cur_pair        <= '0;
      finished        <= 1'b0;
      run_left        <= '0;
    end else if (cmd.take_byte && !finished) begin
      case (mode)
        MODE_LITERAL: begin
          run_left        <= RUN_W'(1);
          remaining_bytes <= remaining_bytes - RUN_W'(1);
          if (remaining_bytes <= RUN_W'(1)) begin
            mode <= MODE_CONTROL;
          end
        end
        MODE_REPEAT: begin
          run_left       <= repeat_pending;
          repeat_pending <= '0;
          mode           <= MODE_CONTROL;
        end
        default: begin
          if (data_byte < REPEAT_FLAG) begin
            remaining_bytes <= data_byte + RUN_W'(1);
            mode            <= MODE_LITERAL;
          end else begin
            repeat_pending <= RUN_W'(REPEAT_BASE - CMP_W'(data_byte));
            mode           <= MODE_REPEAT;
          end
        end
      endcase
    end else if (cmd.emit_seg) begin
      run_left <= run_left - RUN_W'(seg_len);
      if (hit_bottom) begin
        cur_pair <= '0;
        if (col_last) begin
          finished        <= 1'b1;
          mode            <= MODE_CONTROL;
          remaining_bytes <= '0;
          repeat_pending  <= '0;
        end else begin
          cur_col <= cur_col + CIW'(1);
        end
      end else begin
        cur_pair <= PIW'(pair_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      pixel <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_seg) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_seg) begin
      column      <= FIELD_W'(cur_col);
      start_row   <= FIELD_W'({cur_pair, 1'b0});
      pair_count  <= FIELD_W'(seg_len);
      upper_color <= up_tint;
      lower_color <= lo_tint;
      last        <= run_end;
      image_done  <= seg_done;
    end
  end

endmodule

FILE: rtl/nibble_rle_column_decoder.sv
// Top level of the nibble RLE column decoder.
//
// Input channel: one stream byte per beat on data_byte (in_valid/in_ready).
// Control bytes open a literal run (code below 128, 1 to 128 pixel bytes) or
// a repeat run (code 128 and up, one pixel byte repeated 2 to 129 times).
// Output channel: one column segment per beat (out_valid/out_ready) with
// column, start_row, pair_count, two tinted colors, last and image_done.
// Configuration: cfg_wr_en/cfg_index/cfg_data write pairs_per_column (0),
// column_count (1) and base_color (2); write only while the block is idle.
// Sequencing: a control byte is taken and yields nothing; a pixel byte is
// taken and then split into column segments, which go out through the
// segment register one at a time. A literal byte yields one segment; a repeat
// byte yields one segment per column it spans, from the single generator.
// Once the last column completes, further bytes are accepted and dropped
// until reset. If the receiver stalls, the segment register holds and the
// generator waits; no input is taken while a run is still being split.
// Reset restores the register defaults (12, 24, 224) and the decode state.
`timescale 1ns / 1ps

module nibble_rle_column_decoder #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_PAIRS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [nrcd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [nrcd_pkg::DATA_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nrcd_pkg::DATA_W-1:0]   data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nrcd_pkg::FIELD_W-1:0]  column,
  output logic [nrcd_pkg::FIELD_W-1:0]  start_row,
  output logic [nrcd_pkg::FIELD_W-1:0]  pair_count,
  output logic [nrcd_pkg::COLOR_W-1:0]  upper_color,
  output logic [nrcd_pkg::COLOR_W-1:0]  lower_color,
  output logic                          last,
  output logic                          image_done
);
  import nrcd_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  nrcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nrcd_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_byte   (data_byte),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .column      (column),
    .start_row   (start_row),
    .pair_count  (pair_count),
    .upper_color (upper_color),
    .lower_color (lower_color),
    .last        (last),
    .image_done  (image_done)
  );

endmodule

FILE: rtl/nrcd_checker.sv
// Port-level checker for the nibble RLE column decoder, with its bind.
`timescale 1ns / 1ps

module nrcd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [nrcd_pkg::FIELD_W-1:0]  column,
  input logic [nrcd_pkg::FIELD_W-1:0]  start_row,
  input logic [nrcd_pkg::FIELD_W-1:0]  pair_count,
  input logic                          last,
  input logic                          image_done
);
  import nrcd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(column) && $stable(start_row)
      && $stable(pair_count) && $stable(last))
    else $error("segment beat changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> last)
    else $error("image completion not on final segment of byte");

  a_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_count != '0) && !start_row[0])
    else $error("empty segment or odd start row");

  a_quiet_after_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && image_done |=> !out_valid)
    else $error("segment after image completion");

endmodule

bind nibble_rle_column_decoder nrcd_checker u_nrcd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .column     (column),
  .start_row  (start_row),
  .pair_count (pair_count),
  .last       (last),
  .image_done (image_done)
);
